// ----- hw/rtl/ede_pkg.sv -----
package ede_pkg;

  localparam int DEF_MAX_LEN = 64;

  localparam int SYM_W    = 8;
  localparam int OP_W     = 2;
  localparam int DIST_W   = 7;
  localparam int DIST_MAX = 127;

  localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

endpackage

// ----- hw/rtl/ede_ram.sv -----
module ede_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ede_cell_unit.sv -----
module ede_cell_unit #(
  parameter int CW = 7
) (
  input  logic [CW-1:0]              above,
  input  logic [CW-1:0]              left,
  input  logic [CW-1:0]              diag,
  input  logic [ede_pkg::SYM_W-1:0]  sym_a,
  input  logic [ede_pkg::SYM_W-1:0]  sym_b,
  output logic [CW-1:0]              cost
);

  // one extra bit so the +1 terms cannot wrap
  logic [CW:0] del_c;
  logic [CW:0] ins_c;
  logic [CW:0] sub_c;
  logic [CW:0] min_di;
  logic [CW:0] min_all;

  assign del_c = {1'b0, above} + (CW+1)'(1);
  assign ins_c = {1'b0, left} + (CW+1)'(1);
  assign sub_c = {1'b0, diag} + (CW+1)'((sym_a != sym_b) ? 1 : 0);

  assign min_di  = (del_c <= ins_c) ? del_c : ins_c;
  assign min_all = (min_di <= sub_c) ? min_di : sub_c;
  assign cost    = min_all[CW-1:0];

endmodule

// ----- hw/rtl/edit_distance_engine_unit.sv -----
// Levenshtein edit distance engine.
// Input channel (in_*): each request carries an op in in_tuser and a byte in
// in_tdata. Append-to-first and append-to-second add one byte each; bytes
// past MAX_LEN are dropped and noted as overflow. Op 3 is ignored.
// A compute request clears both strings and the overflow note, then runs the
// cost recurrence one cell at a time through a single cell unit and a
// cost-row memory with one read and one write port, and emits one result
// request (distance in out_tdata, overflow in out_tuser).
// After an initial pass that writes row 0, each row is set up by a row-start
// and a row-load step, and each cell then takes a row read and an update.
// in_tready is low for the whole computation.
// The result sits in an output register; appends are accepted while it waits
// to be taken. A further compute runs but holds its result until out_tready
// frees the register.
// Reset (rst_n low, synchronous) empties both strings, clears overflow and
// drops any pending result; no clearing pass is needed.
module edit_distance_engine_unit #(
  parameter int MAX_LEN = ede_pkg::DEF_MAX_LEN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic [1:0] in_tuser,   // [1:0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] distance, [7] zero
  output logic [0:0] out_tuser   // [0] overflow
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int EW = (CW > ede_pkg::DIST_W) ? CW : ede_pkg::DIST_W;
  localparam int SW = ede_pkg::SYM_W;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_INIT      = 7'b0000010,
    ST_ROW_START = 7'b0000100,
    ST_ROW_LOAD  = 7'b0001000,
    ST_CELL_RD   = 7'b0010000,
    ST_CELL_WR   = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] cnt_a_r, cnt_b_r;
  logic          drop_r;
  logic [CW-1:0] n1_r, n2_r;
  logic          ovf_r;
  logic [CW-1:0] row_idx_r, col_r;
  logic [SW-1:0] sym_a_r;
  logic [CW-1:0] diag_r, left_r;
  logic          out_valid_r;
  logic [ede_pkg::DIST_W-1:0] out_dist_r;
  logic          out_ovf_r;

  logic in_acc;
  logic [ede_pkg::OP_W-1:0] in_op;
  logic a_we, b_we;
  logic [SW-1:0] a_rdata, b_rdata;
  logic [CW-1:0] row_m1, col_m1;
  logic          row_we;
  logic [CW-1:0] row_waddr, row_wdata, row_raddr, row_rdata;
  logic [CW-1:0] cell_cost;
  logic          out_free;
  logic [CW-1:0] final_cost;
  logic [EW-1:0] final_ext;
  logic [ede_pkg::DIST_W-1:0] final_dist;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign in_op     = in_tuser;

  assign a_we = in_acc && (in_op == ede_pkg::OP_APPEND_A) && (cnt_a_r < CW'(MAX_LEN));
  assign b_we = in_acc && (in_op == ede_pkg::OP_APPEND_B) && (cnt_b_r < CW'(MAX_LEN));

  assign row_m1 = row_idx_r - CW'(1);
  assign col_m1 = col_r - CW'(1);

  ede_ram #(.WIDTH(SW), .DEPTH(MAX_LEN), .AW(AW)) u_text_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (cnt_a_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (row_m1[AW-1:0]),
    .rdata (a_rdata)
  );

  ede_ram #(.WIDTH(SW), .DEPTH(MAX_LEN), .AW(AW)) u_text_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (cnt_b_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (col_m1[AW-1:0]),
    .rdata (b_rdata)
  );

  always_comb begin
    row_we    = 1'b0;
    row_waddr = col_r;
    row_wdata = cell_cost;
    unique case (state_r)
      ST_INIT: begin
        row_we    = 1'b1;
        row_wdata = col_r;
      end
      ST_ROW_LOAD: begin
        row_we    = 1'b1;
        row_waddr = '0;
        row_wdata = row_idx_r;
      end
      ST_CELL_WR: begin
        row_we = 1'b1;
      end
      default: begin
        row_we = 1'b0;
      end
    endcase
  end

  assign row_raddr = (state_r == ST_ROW_START) ? '0 : col_r;

  ede_ram #(.WIDTH(CW), .DEPTH(MAX_LEN + 1), .AW(CW)) u_cost_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  ede_cell_unit #(.CW(CW)) u_cell (
    .above (row_rdata),
    .left  (left_r),
    .diag  (diag_r),
    .sym_a (sym_a_r),
    .sym_b (b_rdata),
    .cost  (cell_cost)
  );

  assign out_free   = !out_valid_r || out_tready;
  assign final_cost = (n1_r == '0) ? n2_r : left_r;
  assign final_ext  = EW'(final_cost);
  assign final_dist = (final_ext > EW'(ede_pkg::DIST_MAX)) ?
                      ede_pkg::DIST_W'(ede_pkg::DIST_MAX) : final_ext[ede_pkg::DIST_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == ede_pkg::OP_COMPUTE)) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        if (col_r == n2_r) begin
          state_nxt = (n1_r == '0) ? ST_DONE : ST_ROW_START;
        end
      end
      ST_ROW_START: begin
        state_nxt = ST_ROW_LOAD;
      end
      ST_ROW_LOAD: begin
        if (n2_r == '0) begin
          state_nxt = (row_idx_r == n1_r) ? ST_DONE : ST_ROW_START;
        end else begin
          state_nxt = ST_CELL_RD;
        end
      end
      ST_CELL_RD: begin
        state_nxt = ST_CELL_WR;
      end
      ST_CELL_WR: begin
        if (col_r == n2_r) begin
          state_nxt = (row_idx_r == n1_r) ? ST_DONE : ST_ROW_START;
        end else begin
          state_nxt = ST_CELL_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        unique case (in_op)
          ede_pkg::OP_APPEND_A: begin
            if (a_we) cnt_a_r <= cnt_a_r + CW'(1);
            else      drop_r  <= 1'b1;
          end
          ede_pkg::OP_APPEND_B: begin
            if (b_we) cnt_b_r <= cnt_b_r + CW'(1);
            else      drop_r  <= 1'b1;
          end
          ede_pkg::OP_COMPUTE: begin
            cnt_a_r <= '0;
            cnt_b_r <= '0;
            drop_r  <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        n1_r  <= cnt_a_r;
        n2_r  <= cnt_b_r;
        ovf_r <= drop_r;
        col_r <= '0;
      end
      ST_INIT: begin
        col_r     <= col_r + CW'(1);
        row_idx_r <= CW'(1);
      end
      ST_ROW_LOAD: begin
        sym_a_r <= a_rdata;
        diag_r  <= row_rdata;
        left_r  <= row_idx_r;
        col_r   <= CW'(1);
        if (n2_r == '0) row_idx_r <= row_idx_r + CW'(1);
      end
      ST_CELL_WR: begin
        left_r <= cell_cost;
        diag_r <= row_rdata;
        if (col_r == n2_r) row_idx_r <= row_idx_r + CW'(1);
        else               col_r     <= col_r + CW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_dist_r <= final_dist;
          out_ovf_r  <= ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_dist_r};
  assign out_tuser  = out_ovf_r;

endmodule
